FILE: design/kmd_pkg.sv
package kmd_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 8;
  localparam int KEYS      = ROWS * COLS;
  localparam int KEY_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int ROW_W     = 2;
  localparam int COL_W     = 3;
  localparam int TIME_W    = 32;
  localparam int DEB_W     = 16;
  localparam int MASK_BITS = 32;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_HELD     = 2'd2;
  localparam logic [1:0] ST_RELEASED = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_HELD    = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              raw;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] stamp;
    logic [1:0]        status;
  } key_state_t;

  typedef struct packed {
    logic                 wr;
    key_state_t           st;
    logic [MASK_BITS-1:0] mask;
    logic [1:0]           ev;
    logic                 changed;
  } step_t;

  function automatic logic in_matrix(input logic [ROW_W-1:0] row,
                                     input logic [COL_W-1:0] col);
    return (int'(row) < ROWS) && (int'(col) < COLS);
  endfunction

  function automatic logic [KEY_W-1:0] key_index(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return KEY_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

FILE: design/key_matrix_debouncer.sv
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------
// input     | in_valid / in_stall   | key_row, key_col, raw_pressed, now_ms
// output    | out_valid / out_stall | button_mask, key_event, mask_changed
// config    | cfg_wr_en             | cfg_wr_data (debounce_ms)
//
// One request per cycle while out_stall is low; a request passes the input
// register, then the key update lands in the result register and the per-key
// state at once. Throughput is set by the key table's read-modify-write.
// rst is synchronous: clears both stages, the key table, the mask, and loads
// a 50 ms debounce. in_stall rises only when both stages hold requests and
// out_stall is high.
module key_matrix_debouncer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kmd_pkg::ROW_W-1:0]     key_row,
  input  logic [kmd_pkg::COL_W-1:0]     key_col,
  input  logic                          raw_pressed,
  input  logic [kmd_pkg::TIME_W-1:0]    now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kmd_pkg::MASK_BITS-1:0] button_mask,
  output logic [1:0]                    key_event,
  output logic                          mask_changed,
  input  logic                          cfg_wr_en,
  input  logic [kmd_pkg::DEB_W-1:0]     cfg_wr_data
);
  import kmd_pkg::*;

  logic                 s1_valid;
  item_t                s1_item;
  logic [DEB_W-1:0]     debounce_ms;
  logic                 out_free;
  logic                 advance;
  key_state_t           cur_state;
  logic [MASK_BITS-1:0] cur_mask;
  step_t                res;
  logic [KEY_W-1:0]     s1_idx;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign s1_idx   = key_index(s1_item.row, s1_item.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{row: key_row, col: key_col, raw: raw_pressed, now: now_ms};
    end
  end

  kmd_key_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (s1_idx),
    .rd_state (cur_state),
    .mask     (cur_mask),
    .wr_en    (advance && res.wr),
    .wr_idx   (s1_idx),
    .wr_state (res.st),
    .wr_mask  (res.mask)
  );

  kmd_step u_step (
    .item        (s1_item),
    .cur         (cur_state),
    .mask_in     (cur_mask),
    .debounce_ms (debounce_ms),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      button_mask  <= res.mask;
      key_event    <= res.ev;
      mask_changed <= res.changed;
    end
  end

endmodule

FILE: design/kmd_key_store.sv
module kmd_key_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kmd_pkg::KEY_W-1:0]     rd_idx,
  output kmd_pkg::key_state_t           rd_state,
  output logic [kmd_pkg::MASK_BITS-1:0] mask,
  input  logic                          wr_en,
  input  logic [kmd_pkg::KEY_W-1:0]     wr_idx,
  input  kmd_pkg::key_state_t           wr_state,
  input  logic [kmd_pkg::MASK_BITS-1:0] wr_mask
);
  import kmd_pkg::*;

  key_state_t keys [KEYS];

  assign rd_state = keys[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEYS; i++) begin
        keys[i] <= '{level: 1'b0, stamp: '0, status: ST_IDLE};
      end
      mask <= '0;
    end else if (wr_en) begin
      keys[wr_idx] <= wr_state;
      mask         <= wr_mask;
    end
  end

endmodule

FILE: design/kmd_step.sv
module kmd_step (
  input  kmd_pkg::item_t                item,
  input  kmd_pkg::key_state_t           cur,
  input  logic [kmd_pkg::MASK_BITS-1:0] mask_in,
  input  logic [kmd_pkg::DEB_W-1:0]     debounce_ms,
  output kmd_pkg::step_t                res
);
  import kmd_pkg::*;

  logic [KEY_W-1:0]     idx;
  logic [TIME_W-1:0]    elapsed;
  logic [MASK_BITS-1:0] bitv;

  assign idx     = key_index(item.row, item.col);
  assign elapsed = item.now - cur.stamp;  // wraps mod 2^32
  // keys past the mask width still run their status but own no bit
  assign bitv    = (int'(idx) < MASK_BITS) ? (MASK_BITS'(1) << idx) : '0;

  always_comb begin
    res.wr      = 1'b0;
    res.st      = cur;
    res.mask    = mask_in;
    res.ev      = EV_NONE;
    res.changed = 1'b0;
    if (in_matrix(item.row, item.col)) begin
      res.wr = 1'b1;
      if (item.raw != cur.level) begin
        res.st.level = item.raw;
        res.st.stamp = item.now;
      end else if (elapsed >= TIME_W'(debounce_ms)) begin
        if (item.raw && (cur.status inside {ST_IDLE, ST_RELEASED})) begin
          res.st.status = ST_PRESSED;
          res.mask      = mask_in | bitv;
          res.ev        = EV_PRESS;
          res.changed   = 1'b1;
        end else if (!item.raw && (cur.status inside {ST_PRESSED, ST_HELD})) begin
          res.st.status = ST_RELEASED;
          res.mask      = mask_in & ~bitv;
          res.ev        = EV_RELEASE;
          res.changed   = 1'b1;
        end else if (cur.status == ST_PRESSED) begin
          res.st.status = ST_HELD;
          res.ev        = EV_HELD;
        end
      end
    end
  end

endmodule

FILE: design/kmd_checker.sv
module kmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kmd_pkg::MASK_BITS-1:0] button_mask,
  input logic [1:0]                    key_event,
  input logic                          mask_changed
);
  import kmd_pkg::*;

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(button_mask) &&
      $stable(key_event) && $stable(mask_changed))
    else $error("stalled result changed");

  a_changed_ev: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mask_changed == (key_event == EV_PRESS || key_event == EV_RELEASE))
    else $error("mask_changed disagrees with key_event");

  // input backs up only behind a stalled, full output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .button_mask  (button_mask),
  .key_event    (key_event),
  .mask_changed (mask_changed)
);
